// ----- design/a2lp_pkg.sv -----
package a2lp_pkg;

  localparam int ADDR_BITS  = 24;
  localparam int ADDR_OUT_W = 24;
  localparam int VALUE_W    = 32;
  localparam int CNT_W      = 3;   // payload writes per item, 0..4
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_LENGTH = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] len;
    logic                 ovf;
  } close_t;

  // one accepted byte's worth of writes: cnt payload bytes from base, then c1, then c2
  typedef struct packed {
    logic                 last;
    logic [CNT_W-1:0]     cnt;
    logic                 useb;
    logic [7:0]           data;
    logic [ADDR_BITS-1:0] base;
    logic                 ovf;
    close_t               c1;
    close_t               c2;
  } desc_t;

endpackage

// ----- design/a2lp_in_if.sv -----
interface a2lp_in_if import a2lp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// ----- design/a2lp_out_if.sv -----
interface a2lp_out_if import a2lp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  write_kind;
  logic [ADDR_OUT_W-1:0] write_addr;
  logic [VALUE_W-1:0]    write_value;
  logic                  overflow;
  logic                  last_write;

  modport source (output valid, write_kind, write_addr, write_value, overflow, last_write,
                  input ready);
  modport sink   (input valid, write_kind, write_addr, write_value, overflow, last_write,
                  output ready);
endinterface

// ----- design/a2lp_front.sv -----
module a2lp_front import a2lp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  a2lp_in_if.sink    byte_in,
  input  logic       full,
  output logic       push,
  output desc_t      desc
);

  logic [1:0]           held_zeros;
  logic                 in_unit;
  logic [ADDR_BITS-1:0] unit_length;
  logic [ADDR_BITS-1:0] header_addr;
  logic [ADDR_BITS-1:0] write_ptr;
  logic                 overflow_flag;

  logic                 accept;
  logic                 open_u, close_old;
  logic [CNT_W-1:0]     n, cnt, inc;
  logic [1:0]           held_zeros_next, m;
  logic                 in_unit_next, overflow_flag_next;
  logic [ADDR_BITS:0]   sum;
  logic [ADDR_BITS-1:0] write_ptr_next, unit_length_next, header_addr_next;
  close_t               fc;

  assign byte_in.ready = !full;
  assign accept        = byte_in.valid && !full;

  always_comb begin
    open_u          = 1'b0;
    close_old       = 1'b0;
    n               = '0;
    desc.useb       = 1'b0;
    held_zeros_next = held_zeros;
    if (!in_unit) begin
      if (byte_in.data_byte == 8'h01 && held_zeros[1]) begin
        open_u = 1'b1;
      end else if (byte_in.data_byte == 8'h00) begin
        held_zeros_next = (held_zeros == 2'd3) ? 2'd3 : held_zeros + 2'd1;
      end else begin
        held_zeros_next = '0;
      end
    end else begin
      if (byte_in.data_byte == 8'h00) begin
        if (held_zeros != 2'd3) held_zeros_next = held_zeros + 2'd1;
        else n = CNT_W'(1);
      end else if (byte_in.data_byte == 8'h01 && held_zeros[1]) begin
        close_old = 1'b1;
        open_u    = 1'b1;
      end else begin
        n               = CNT_W'(held_zeros) + CNT_W'(1);
        desc.useb       = 1'b1;
        held_zeros_next = '0;
      end
    end
    if (open_u) held_zeros_next = '0;
    in_unit_next = in_unit | open_u;

    // on the last byte the held zeros go out straight after this byte's payload
    m   = (byte_in.last_byte && in_unit_next) ? held_zeros_next : 2'd0;
    cnt = n + CNT_W'(m);
    inc = open_u ? CNT_W'(4) : cnt;
    sum = {1'b0, write_ptr} + (ADDR_BITS+1)'(inc);
    write_ptr_next     = sum[ADDR_BITS-1:0];
    overflow_flag_next = overflow_flag | sum[ADDR_BITS];
    unit_length_next   = open_u ? '0 : unit_length + ADDR_BITS'(cnt);
    header_addr_next   = open_u ? write_ptr : header_addr;

    fc.valid = 1'b1;
    fc.ovf   = overflow_flag_next;
    if (in_unit_next) begin
      fc.addr = header_addr_next;
      fc.len  = unit_length_next;
    end else begin
      fc.addr = write_ptr_next;
      fc.len  = '0;
    end

    desc.last = byte_in.last_byte;
    desc.cnt  = cnt;
    desc.data = byte_in.data_byte;
    desc.base = write_ptr;
    desc.ovf  = overflow_flag;
    desc.c1   = '0;
    desc.c2   = '0;
    if (close_old) begin
      desc.c1 = '{valid: 1'b1, addr: header_addr, len: unit_length, ovf: overflow_flag};
      if (byte_in.last_byte) desc.c2 = fc;
    end else if (byte_in.last_byte) begin
      desc.c1 = fc;
    end

    push = accept && (cnt != '0 || close_old || byte_in.last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && byte_in.last_byte)) begin
      held_zeros    <= '0;
      in_unit       <= 1'b0;
      unit_length   <= '0;
      header_addr   <= '0;
      write_ptr     <= '0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      held_zeros    <= held_zeros_next;
      in_unit       <= in_unit_next;
      unit_length   <= unit_length_next;
      header_addr   <= header_addr_next;
      write_ptr     <= write_ptr_next;
      overflow_flag <= overflow_flag_next;
    end
  end

endmodule

// ----- design/a2lp_queue.sv -----
module a2lp_queue import a2lp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output desc_t head,
  output logic  empty
);

  desc_t             q [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = q[rptr];

  always_ff @(posedge clk) begin
    if (push) q[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ----- design/a2lp_back.sv -----
module a2lp_back import a2lp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  desc_t       head,
  input  logic        empty,
  output logic        pop,
  a2lp_out_if.source  write_out
);

  logic [CNT_W-1:0]     k;
  logic [CNT_W-1:0]     tot;
  logic                 advance, final_w, is_pay;
  logic [ADDR_BITS:0]   psum;
  close_t               csel;
  logic                 kind_c;
  logic [ADDR_BITS-1:0] addr_c;
  logic [VALUE_W-1:0]   value_c;
  logic                 ovf_c;

  assign tot     = head.cnt + CNT_W'(head.c1.valid) + CNT_W'(head.c2.valid);
  assign final_w = (k == tot - CNT_W'(1));
  assign advance = !empty && (!write_out.valid || write_out.ready);
  assign pop     = advance && final_w;
  assign is_pay  = (k < head.cnt);

  always_comb begin
    psum = {1'b0, head.base} + (ADDR_BITS+1)'(k) + (ADDR_BITS+1)'(1);
    csel = (k == head.cnt && head.c1.valid) ? head.c1 : head.c2;
    if (is_pay) begin
      kind_c  = KIND_BYTE;
      addr_c  = head.base + ADDR_BITS'(k);
      value_c = (head.useb && k == head.cnt - CNT_W'(1)) ? VALUE_W'(head.data) : '0;
      ovf_c   = head.ovf | psum[ADDR_BITS];
    end else begin
      kind_c  = KIND_LENGTH;
      addr_c  = csel.addr;
      value_c = VALUE_W'(csel.len);
      ovf_c   = csel.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k               <= '0;
      write_out.valid <= 1'b0;
    end else if (advance) begin
      k               <= final_w ? '0 : k + CNT_W'(1);
      write_out.valid <= 1'b1;
    end else if (write_out.ready) begin
      write_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      write_out.write_kind  <= kind_c;
      write_out.write_addr  <= ADDR_OUT_W'(addr_c);
      write_out.write_value <= value_c;
      write_out.overflow    <= ovf_c;
      write_out.last_write  <= head.last && final_w;
    end
  end

endmodule

// ----- design/annexb_to_length_prefixed.sv -----
// channel    dir  handshake    fields
// byte_in    in   valid/ready  data_byte, last_byte
// write_out  out  valid/ready  write_kind, write_addr, write_value, overflow, last_write
//
// One byte accepted per cycle while the four-entry queue has room; the front end
// classifies the byte and updates pointers in that same cycle.
// The back end issues one write per cycle while the output is ready, up to five per
// byte, so a byte that flushes held zeros and closes a unit holds the output for all of them.
// A byte goes through a queue entry, then the output register. rst is synchronous,
// active high. A stalled output only back-pressures the input once the queue fills.
module annexb_to_length_prefixed import a2lp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  a2lp_in_if.sink    byte_in,
  a2lp_out_if.source write_out
);

  logic  push, full, pop, empty;
  desc_t push_data, head;

  a2lp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .full    (full),
    .push    (push),
    .desc    (push_data)
  );

  a2lp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  a2lp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .write_out (write_out)
  );

  // a buffer always ends with a length write
  a_last_is_length: assert property (@(posedge clk) disable iff (rst)
    write_out.valid && write_out.last_write |-> write_out.write_kind == KIND_LENGTH)
    else $error("last write is not a length write");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue pop while empty");

  // the final byte of a buffer always queues at least its length write
  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    byte_in.valid && byte_in.ready && byte_in.last_byte |-> push)
    else $error("last byte produced no writes");

endmodule
